@@ rtl/macb_pkg.sv @@
// shared types and constants of the multiplexed address counter bank
package macb_pkg;

    localparam int NUM_CTRS = 8;
    localparam int SEL_W    = 3;
    localparam int CNT_W    = 13;
    localparam int PHASE_W  = 4;
    localparam int LINE_W   = 8;
    localparam int CMD_W    = 2;

    localparam logic [CNT_W-1:0]  CNT_CEIL   = 13'd8191;
    localparam logic [LINE_W-1:0] START_INIT = 8'hff;
    localparam logic [LINE_W-1:0] CLOCK_INIT = 8'h00;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_START  = 2'd1,
        CMD_CLOCK  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef logic [CNT_W-1:0] cnt_t;

endpackage

@@ rtl/multiplexed_address_counter_bank.sv @@
// Eight 13-bit address counters behind one multiplexed tick output. Each accepted
// transaction is either a start-line write (a falling edge clears that counter),
// a clock-line write (a falling edge increments that counter, saturating at the
// maximum count) or a tick, which returns the 4-bit phase and the counter picked by
// its low three bits and then advances the phase. One transaction is taken every
// cycle; a transaction lands in an input register and is executed from there by
// single-pass logic, and a tick's result is registered in the output register.
// Throughput drops below one per cycle only while a tick waits for the output
// register to be emptied by out_ready. Counters reset to the maximum count, start
// levels to all ones, clock levels and phase to zero.
module multiplexed_address_counter_bank (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [macb_pkg::CMD_W-1:0]   command,
    input  logic [macb_pkg::LINE_W-1:0]  line_bits,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [macb_pkg::PHASE_W-1:0] phase,
    output logic [macb_pkg::CNT_W-1:0]   count_value
);
    import macb_pkg::*;

    // input stage
    logic              in_vld_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [LINE_W-1:0] bits_reg;

    // block state
    cnt_t              cnt_reg   [NUM_CTRS];
    cnt_t              cnt_next  [NUM_CTRS];
    logic [LINE_W-1:0] start_reg;
    logic [LINE_W-1:0] start_next;
    logic [LINE_W-1:0] clock_reg;
    logic [LINE_W-1:0] clock_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;

    // result stage
    logic               out_vld_reg;
    logic [PHASE_W-1:0] out_phase_reg;
    cnt_t               out_cnt_reg;

    logic out_free;
    logic stage_go;
    logic tick_go;
    logic start_go;
    logic clock_go;

    assign out_free = !out_vld_reg || out_ready;
    assign stage_go = in_vld_reg && ((cmd_reg != CMD_TICK) || out_free);
    assign in_ready = !in_vld_reg || stage_go;

    always_comb
    begin
        tick_go  = 1'b0;
        start_go = 1'b0;
        clock_go = 1'b0;
        unique case (cmd_reg)
            CMD_TICK:  tick_go  = stage_go;
            CMD_START: start_go = stage_go;
            CMD_CLOCK: clock_go = stage_go;
            default:   ;
        endcase
    end

    always_comb
    begin
        start_next = start_go ? bits_reg : start_reg;
        clock_next = clock_go ? bits_reg : clock_reg;
        phase_next = tick_go ? PHASE_W'(phase_reg + 1'b1) : phase_reg;
        for (int i = 0; i < NUM_CTRS; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            // falling edge on an active-low line
            if (start_go && start_reg[i] && !bits_reg[i])
            begin
                cnt_next[i] = '0;
            end
            else if (clock_go && clock_reg[i] && !bits_reg[i] && (cnt_reg[i] < CNT_CEIL))
            begin
                cnt_next[i] = CNT_W'(cnt_reg[i] + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            start_reg   <= START_INIT;
            clock_reg   <= CLOCK_INIT;
            phase_reg   <= '0;
            for (int i = 0; i < NUM_CTRS; i++)
            begin
                cnt_reg[i] <= CNT_CEIL;
            end
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (out_free)
            begin
                out_vld_reg <= tick_go;
            end
            start_reg <= start_next;
            clock_reg <= clock_next;
            phase_reg <= phase_next;
            for (int i = 0; i < NUM_CTRS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= command;
            bits_reg <= line_bits;
        end
        if (tick_go)
        begin
            out_phase_reg <= phase_reg;
            out_cnt_reg   <= cnt_reg[phase_reg[SEL_W-1:0]];
        end
    end

    assign out_valid   = out_vld_reg;
    assign phase       = out_phase_reg;
    assign count_value = out_cnt_reg;

`ifndef SYNTHESIS
    // phase moves exactly on an executed tick
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_go |=> phase_reg == PHASE_W'($past(phase_reg) + 1'b1))
        else $error("phase did not advance after tick");

    assert property (@(posedge clk) disable iff (!rst_n)
        !tick_go |=> phase_reg == $past(phase_reg))
        else $error("phase changed without tick");

    // a new result only comes from a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(tick_go))
        else $error("result without tick");

    // input stalls only behind a blocked tick
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_vld_reg && cmd_reg == CMD_TICK && out_vld_reg && !out_ready))
        else $error("input stalled without cause");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start_go && start_reg[0] && !bits_reg[0]) |=> cnt_reg[0] == '0)
        else $error("start edge did not clear counter");
`endif

endmodule
